@@ rtl/hsv_pkg.sv @@
// Shared constants and types for the HSV to RGB color converter.
package hsv_pkg;

  // Input and output field widths
  localparam int HUE_W  = 15;
  localparam int FRAC_W = 13;
  localparam int CHAN_W = 8;
  localparam int REM_W  = 12;
  localparam int SEC_W  = 4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Hue geometry in 1/64 degree units
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam int               NUM_SECT_BOUNDS = 8;

  // x / 3840 = (x >> 8) / 15, the division by 15 done as a reciprocal multiply
  localparam int          PRE_SHIFT   = 8;
  localparam int          RECIP_SHIFT = 28;
  localparam int          RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 25'd17895698;

  localparam logic [CHAN_W:0] CHAN_SCALE = 9'd255;

  typedef logic [SEC_W-1:0] sector_t;

  // Sector codes for five of the six 60 degree spans
  localparam sector_t SEC_RED_YEL = 4'd0;
  localparam sector_t SEC_YEL_GRN = 4'd1;
  localparam sector_t SEC_GRN_CYN = 4'd2;
  localparam sector_t SEC_CYN_BLU = 4'd3;
  localparam sector_t SEC_BLU_MAG = 4'd4;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB color converter: six-stage pipeline, one color per clock unless stalled.
// An accepted request moves through every stage register in turn before out_tvalid.
// Throughput: one request per clock unless the output stalls; multipliers sit in
// stages 2, 3, 5 and 6 (recip multiply for hue fraction, then brightness products).
// The whole pipeline stalls together while the output register is held.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module hsv_to_rgb_converter
  import hsv_pkg::*;
#(
  parameter int UNIT_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [14:0] hue, [27:15] saturation, [40:28] brightness, [47:41] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW   = UNIT_BITS + 1;
  localparam int XW   = (CW > FRAC_W) ? CW : FRAC_W;
  localparam int PW   = CW + REM_W;
  localparam int YW   = PW - PRE_SHIFT;
  localparam int RPW  = YW + RECIP_W;
  localparam int NUM_STAGES = 6;

  localparam logic [CW-1:0] UNIT   = CW'(1) << UNIT_BITS;
  localparam logic [XW-1:0] UNIT_X = XW'(1) << UNIT_BITS;

  logic [NUM_STAGES-1:0] vld_r;
  logic                  en;

  assign en        = !vld_r[NUM_STAGES-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  // Stage 1: clamp, wrap full turn, split hue into sector and remainder
  logic [HUE_W-1:0]  hue_in, hue_w;
  logic [XW-1:0]     sat_x, bri_x;
  logic [CW-1:0]     s1_s_nxt, s1_v_nxt;
  sector_t           s1_sec_nxt;
  logic [REM_W-1:0]  s1_rem_nxt;
  logic [CW-1:0]     s1_s_r, s1_v_r;
  sector_t           s1_sec_r;
  logic [REM_W-1:0]  s1_rem_r;

  always_comb begin
    sector_t sec;
    hue_in = in_tdata[HUE_W-1:0];
    sat_x  = XW'(in_tdata[HUE_W +: FRAC_W]);
    bri_x  = XW'(in_tdata[HUE_W+FRAC_W +: FRAC_W]);
    s1_s_nxt = (sat_x > UNIT_X) ? UNIT : CW'(sat_x);
    s1_v_nxt = (bri_x > UNIT_X) ? UNIT : CW'(bri_x);
    hue_w = (hue_in == HUE_FULL) ? '0 : hue_in;
    sec = '0;
    for (int k = 1; k <= NUM_SECT_BOUNDS; k++) begin
      if (hue_w >= HUE_W'(k * HUE_SECTOR)) sec = sec + sector_t'(1);
    end
    s1_sec_nxt = sec;
    s1_rem_nxt = REM_W'(hue_w - HUE_W'(sec * HUE_SECTOR));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r   <= s1_s_nxt;
      s1_v_r   <= s1_v_nxt;
      s1_sec_r <= s1_sec_nxt;
      s1_rem_r <= s1_rem_nxt;
    end
  end

  // Stage 2: saturation times hue fraction and its complement
  logic [PW-1:0] s2_fr_nxt, s2_fc_nxt;
  logic [PW-1:0] s2_fr_r, s2_fc_r;
  logic [CW-1:0] s2_ns_r, s2_v_r;
  sector_t       s2_sec_r;

  assign s2_fr_nxt = PW'(s1_s_r) * PW'(s1_rem_r);
  assign s2_fc_nxt = PW'(s1_s_r) * PW'(REM_W'(HUE_SECTOR) - s1_rem_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_fr_r  <= s2_fr_nxt;
      s2_fc_r  <= s2_fc_nxt;
      s2_ns_r  <= UNIT - s1_s_r;
      s2_v_r   <= s1_v_r;
      s2_sec_r <= s1_sec_r;
    end
  end

  // Stage 3: divide by one sector width through the reciprocal
  logic [RPW-1:0] s3_fr_nxt, s3_fc_nxt;
  logic [RPW-1:0] s3_fr_r, s3_fc_r;
  logic [CW-1:0]  s3_ns_r, s3_v_r;
  sector_t        s3_sec_r;

  assign s3_fr_nxt = RPW'(s2_fr_r[PW-1:PRE_SHIFT]) * RPW'(RECIP_MUL);
  assign s3_fc_nxt = RPW'(s2_fc_r[PW-1:PRE_SHIFT]) * RPW'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fr_r  <= s3_fr_nxt;
      s3_fc_r  <= s3_fc_nxt;
      s3_ns_r  <= s2_ns_r;
      s3_v_r   <= s2_v_r;
      s3_sec_r <= s2_sec_r;
    end
  end

  // Stage 4: complement factors for q and t
  logic [CW-1:0] s4_nq_r, s4_nt_r, s4_ns_r, s4_v_r;
  sector_t       s4_sec_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nq_r  <= UNIT - s3_fr_r[RECIP_SHIFT +: CW];
      s4_nt_r  <= UNIT - s3_fc_r[RECIP_SHIFT +: CW];
      s4_ns_r  <= s3_ns_r;
      s4_v_r   <= s3_v_r;
      s4_sec_r <= s3_sec_r;
    end
  end

  // Stage 5: p, q, t as brightness products
  logic [2*CW-1:0] pm, qm, tm;
  logic [CW-1:0]   s5_p_r, s5_q_r, s5_t_r, s5_v_r;
  sector_t         s5_sec_r;

  assign pm = (2*CW)'(s4_v_r) * (2*CW)'(s4_ns_r);
  assign qm = (2*CW)'(s4_v_r) * (2*CW)'(s4_nq_r);
  assign tm = (2*CW)'(s4_v_r) * (2*CW)'(s4_nt_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p_r   <= pm[UNIT_BITS +: CW];
      s5_q_r   <= qm[UNIT_BITS +: CW];
      s5_t_r   <= tm[UNIT_BITS +: CW];
      s5_v_r   <= s4_v_r;
      s5_sec_r <= s4_sec_r;
    end
  end

  // Stage 6: pick channels by sector and scale to bytes.
  // Zero saturation needs no special arm: p, q and t all equal v then.
  logic [CW-1:0]   r_x, g_x, b_x;
  logic [CW+8:0]   r_m, g_m, b_m;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_comb begin
    case (s5_sec_r)
      SEC_RED_YEL: begin r_x = s5_v_r; g_x = s5_t_r; b_x = s5_p_r; end
      SEC_YEL_GRN: begin r_x = s5_q_r; g_x = s5_v_r; b_x = s5_p_r; end
      SEC_GRN_CYN: begin r_x = s5_p_r; g_x = s5_v_r; b_x = s5_t_r; end
      SEC_CYN_BLU: begin r_x = s5_p_r; g_x = s5_q_r; b_x = s5_v_r; end
      SEC_BLU_MAG: begin r_x = s5_t_r; g_x = s5_p_r; b_x = s5_v_r; end
      default:     begin r_x = s5_v_r; g_x = s5_p_r; b_x = s5_q_r; end
    endcase
    r_m = (CW+9)'(r_x) * (CW+9)'(CHAN_SCALE);
    g_m = (CW+9)'(g_x) * (CW+9)'(CHAN_SCALE);
    b_m = (CW+9)'(b_x) * (CW+9)'(CHAN_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {b_m[UNIT_BITS +: CHAN_W], g_m[UNIT_BITS +: CHAN_W],
                      r_m[UNIT_BITS +: CHAN_W]};
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = out_tdata_r;

  // A stall freezes every stage's valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // An accepted request occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted request not captured");

  // Fraction products never exceed saturation, so q and t factors stay no lower than p's
  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (s4_nq_r >= s4_ns_r) && (s4_nt_r >= s4_ns_r))
    else $error("hue fraction exceeds saturation");

  a_p_smallest: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (s5_p_r <= s5_q_r) && (s5_p_r <= s5_t_r) && (s5_q_r <= s5_v_r))
    else $error("p, q, t ordering broken");

endmodule

@@ bench/tb_hsv_to_rgb_converter.sv @@
// Self-checking testbench for the HSV to RGB color converter stream block.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter
  import hsv_pkg::*;
();

  localparam int UNIT_BITS      = 12;
  localparam int CLK_PERIOD     = 8;
  localparam int PIPE_LAT       = 6;
  localparam int RANDOM_ITEMS   = 600;
  localparam int IDLE_LIMIT     = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AFTER_OUT = 150;

  // Packed so the last field, hue, lands in the lowest bits of tdata
  typedef struct packed {
    logic [IN_TDATA_W-HUE_W-2*FRAC_W-1:0] pad;
    logic [FRAC_W-1:0]                    bright;
    logic [FRAC_W-1:0]                    sat;
    logic [HUE_W-1:0]                     hue;
  } color_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  color_req_t color_pending[$];
  rgb_t       rgb_expected[$];
  int         mismatch_count = 0;
  int         colors_out     = 0;
  bit         in_taken       = 1'b0;

  int gap_left   = 0;
  int burst_left = 0;
  int hold_left  = 0;
  int mode_left  = 0;
  int ready_mode = 0;
  int ready_tick = 0;
  bit long_hold_done = 1'b0;
  int idle_cycles = 0;

  hsv_to_rgb_converter #(.UNIT_BITS(UNIT_BITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned to_byte(int unsigned x);
    int unsigned b;
    b = (x * 255) >> UNIT_BITS;
    return (b > 255) ? 255 : b;
  endfunction

  function automatic rgb_t hsv_to_rgb_bytes(color_req_t c);
    int unsigned unit, h, s, v, sector, rem, sf, sfc, p, q, t, r, g, b;
    rgb_t o;
    unit = 1 << UNIT_BITS;
    h = 32'(c.hue);
    s = (32'(c.sat) > unit) ? unit : 32'(c.sat);
    v = (32'(c.bright) > unit) ? unit : 32'(c.bright);
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      // a full turn wraps back to the red sector
      if (h == HUE_FULL) h = 0;
      sector = h / HUE_SECTOR;
      rem    = h % HUE_SECTOR;
      sf     = (s * rem) / HUE_SECTOR;
      sfc    = (s * (HUE_SECTOR - rem)) / HUE_SECTOR;
      p = (v * (unit - s)) >> UNIT_BITS;
      q = (v * (unit - sf)) >> UNIT_BITS;
      t = (v * (unit - sfc)) >> UNIT_BITS;
      case (sector_t'(sector))
        SEC_RED_YEL: begin r = v; g = t; b = p; end
        SEC_YEL_GRN: begin r = q; g = v; b = p; end
        SEC_GRN_CYN: begin r = p; g = v; b = t; end
        SEC_CYN_BLU: begin r = p; g = q; b = v; end
        SEC_BLU_MAG: begin r = t; g = p; b = v; end
        default:     begin r = v; g = p; b = q; end
      endcase
    end
    o.red   = CHAN_W'(to_byte(r));
    o.green = CHAN_W'(to_byte(g));
    o.blue  = CHAN_W'(to_byte(b));
    return o;
  endfunction

  task automatic queue_color(int unsigned h, int unsigned s, int unsigned v);
    color_req_t c;
    c.pad    = '0;
    c.hue    = HUE_W'(h);
    c.sat    = FRAC_W'(s);
    c.bright = FRAC_W'(v);
    color_pending.push_back(c);
  endtask

  function automatic int unsigned pick_frac();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1 << UNIT_BITS;
      2, 3:    return $urandom_range(0, (1 << FRAC_W) - 1);
      default: return $urandom_range(0, 1 << UNIT_BITS);
    endcase
  endfunction

  function automatic int unsigned pick_hue();
    int unsigned k;
    k = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, (1 << HUE_W) - 1);
      1:       return HUE_FULL;
      // straddle a sector boundary
      2:       return (k * HUE_SECTOR == 0) ? $urandom_range(0, 1)
                                            : k * HUE_SECTOR - 1 + $urandom_range(0, 2);
      default: return $urandom_range(0, HUE_FULL);
    endcase
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Request driver: bursts with random gaps, holds a request until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_taken) void'(color_pending.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (color_pending.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= color_pending[0];
        if (burst_left <= 1) begin
          case ($urandom_range(0, 3))
            0: begin
              gap_left   = 0;
              burst_left = $urandom_range(30, 80);
            end
            default: begin
              gap_left   = $urandom_range(1, 5);
              burst_left = $urandom_range(1, 12);
            end
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall patterns plus one long hold-off
  always @(negedge clk) begin
    ready_tick++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && colors_out >= HOLD_AFTER_OUT) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (ready_tick % 4) != 0;
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Capture accepted requests and check accepted results
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        rgb_expected.push_back(hsv_to_rgb_bytes(color_req_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        colors_out++;
        got = rgb_t'(out_tdata);
        if (rgb_expected.size() == 0) begin
          report_error($sformatf("unexpected result 0x%06h", out_tdata));
        end else begin
          want = rgb_expected.pop_front();
          if (got.red != want.red)
            report_error($sformatf("red %0d, want %0d", got.red, want.red));
          if (got.green != want.green)
            report_error($sformatf("green %0d, want %0d", got.green, want.green));
          if (got.blue != want.blue)
            report_error($sformatf("blue %0d, want %0d", got.blue, want.blue));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // corners: full turn, sector edges, grey, clamped saturation and brightness
    queue_color(0, 4096, 4096);
    queue_color(HUE_FULL, 4096, 4096);
    queue_color(HUE_FULL - 1, 4096, 4096);
    queue_color(HUE_SECTOR - 1, 4096, 4096);
    for (int k = 1; k <= 5; k++) queue_color(k * HUE_SECTOR, 4096, 4096);
    for (int k = 0; k <= 5; k++) queue_color(k * HUE_SECTOR + 1234, 3000, 3500);
    queue_color(26880, 4096, 4096);
    queue_color((1 << HUE_W) - 1, (1 << FRAC_W) - 1, (1 << FRAC_W) - 1);
    queue_color(5000, 0, 3000);
    queue_color(0, 0, (1 << FRAC_W) - 1);
    queue_color(0, 0, 0);
    queue_color(12345, 4097, 4095);
    queue_color(2000, 1, 4096);
    queue_color(20000, 4096, 0);
    queue_color(15000, 100, 8191);
    for (int n = 0; n < RANDOM_ITEMS; n++) queue_color(pick_hue(), pick_frac(), pick_frac());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (color_pending.size() != 0) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (4 * PIPE_LAT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
